[hw/rtl/bgc_pkg.sv]
// Package: shared types and constants for the button gesture classifier.
`default_nettype none

package bgc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_RELEASED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } gesture_t;

    localparam int unsigned TIMER_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

    localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [TIMER_W-1:0] SETTLE_RESET   = 16'd300;
    localparam logic [TIMER_W-1:0] LONG_RESET     = 16'd1000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

[hw/rtl/button_gesture_classifier_unit.sv]
// Top level: button gesture classifier with debounce, click counting and long-press timing.
//
// Input channel (in_valid/in_ready) carries one button sample and a millisecond tick
// flag per transaction. Output channel (out_valid/out_ready) returns exactly one
// result per input transaction: gesture_event (0 none, 1 single, 2 double, 3 long)
// and phase_now, the phase after that sample.
// The state update for a sample happens at its acceptance edge and the result is
// held in the output register from the next cycle on.
// Throughput is one sample per cycle while the receiver keeps out_ready high; the
// combinational state update (timer decrement, compare and phase selection) feeds the output register.
// in_ready is high while the output register is empty or being drained in the
// same cycle; a stalled receiver keeps the result held and blocks new samples.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge;
// an index past the last register is ignored.
// Reset loads debounce 10, settle 300 and long press 1000 ticks, returns to idle
// with a zero timer and zero counts, and empties the output register.
`default_nettype none

module button_gesture_classifier_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bgc_pkg::TIMER_W-1:0]     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            button_level,
    input  wire logic                            tick,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           gesture_event,
    output logic [1:0]                           phase_now
);

    logic [bgc_pkg::TIMER_W-1:0] debounce_reg;
    logic [bgc_pkg::TIMER_W-1:0] settle_reg;
    logic [bgc_pkg::TIMER_W-1:0] long_reg;

    bgc_pkg::phase_t             phase_reg, phase_next;
    logic [bgc_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [bgc_pkg::COUNT_W-1:0] short_reg, short_next;
    logic [bgc_pkg::COUNT_W-1:0] long_cnt_reg, long_cnt_next;
    logic                        last_level_reg;
    logic                        pending_reg, pending_next;

    logic                        out_valid_reg;
    bgc_pkg::gesture_t           event_reg, event_next;
    bgc_pkg::phase_t             phase_out_reg;

    logic                        accept;
    logic [bgc_pkg::TIMER_W-1:0] timer_dec;
    logic                        done;
    logic [bgc_pkg::TIMER_W:0]   long_diff;

    assign in_ready      = !out_valid_reg || out_ready;
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign gesture_event = event_reg;
    assign phase_now     = phase_out_reg;

    assign timer_dec = (tick && (timer_reg != '0)) ? timer_reg - 1'b1 : timer_reg;
    assign done      = (timer_dec == '0);
    assign long_diff = {1'b0, long_reg} - {1'b0, debounce_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_dec;
        short_next    = short_reg;
        long_cnt_next = long_cnt_reg;
        pending_next  = pending_reg;
        event_next    = bgc_pkg::EV_NONE;
        unique case (phase_reg)
            bgc_pkg::PH_IDLE:
            begin
                if (!last_level_reg && button_level)
                begin
                    phase_next = bgc_pkg::PH_DEBOUNCE;
                    timer_next = debounce_reg;
                end
            end
            bgc_pkg::PH_DEBOUNCE:
            begin
                if (done)
                begin
                    if (button_level)
                    begin
                        phase_next = bgc_pkg::PH_PRESSED;
                        timer_next = long_diff[bgc_pkg::TIMER_W] ? '0
                                   : long_diff[bgc_pkg::TIMER_W-1:0];
                    end
                    else
                    begin
                        phase_next = bgc_pkg::PH_RELEASED;
                    end
                end
            end
            bgc_pkg::PH_PRESSED:
            begin
                if (!button_level)
                begin
                    if (done)
                    begin
                        if (long_cnt_reg != bgc_pkg::COUNT_MAX)
                        begin
                            long_cnt_next = long_cnt_reg + 1'b1;
                        end
                    end
                    else if (short_reg != bgc_pkg::COUNT_MAX)
                    begin
                        short_next = short_reg + 1'b1;
                    end
                    phase_next = bgc_pkg::PH_RELEASED;
                    timer_next = debounce_reg;
                end
            end
            bgc_pkg::PH_RELEASED:
            begin
                if (done)
                begin
                    if (!pending_reg)
                    begin
                        timer_next   = settle_reg;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        priority if (short_reg == 8'd1)
                        begin
                            event_next = bgc_pkg::EV_SINGLE;
                        end
                        else if (short_reg == 8'd2)
                        begin
                            event_next = bgc_pkg::EV_DOUBLE;
                        end
                        else if (long_cnt_reg == 8'd1)
                        begin
                            event_next = bgc_pkg::EV_LONG;
                        end
                        else
                        begin
                            event_next = bgc_pkg::EV_NONE;
                        end
                        phase_next    = bgc_pkg::PH_IDLE;
                        short_next    = '0;
                        long_cnt_next = '0;
                        pending_next  = 1'b0;
                    end
                end
                else if (button_level && pending_reg)
                begin
                    phase_next   = bgc_pkg::PH_DEBOUNCE;
                    timer_next   = debounce_reg;
                    pending_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = bgc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bgc_pkg::DEBOUNCE_RESET;
            settle_reg   <= bgc_pkg::SETTLE_RESET;
            long_reg     <= bgc_pkg::LONG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bgc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                bgc_pkg::CFG_SETTLE:   settle_reg   <= cfg_data;
                bgc_pkg::CFG_LONG:     long_reg     <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bgc_pkg::PH_IDLE;
            timer_reg      <= '0;
            short_reg      <= '0;
            long_cnt_reg   <= '0;
            last_level_reg <= 1'b0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            event_reg      <= bgc_pkg::EV_NONE;
            phase_out_reg  <= bgc_pkg::PH_IDLE;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                short_reg      <= short_next;
                long_cnt_reg   <= long_cnt_next;
                last_level_reg <= button_level;
                pending_reg    <= pending_next;
                event_reg      <= event_next;
                phase_out_reg  <= phase_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_event_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (gesture_event != bgc_pkg::EV_NONE)) |-> (phase_now == bgc_pkg::PH_IDLE))
        else $error("gesture reported outside idle phase");

    a_idle_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bgc_pkg::PH_IDLE) |-> ((short_reg == '0) && (long_cnt_reg == '0)))
        else $error("press counts not cleared in idle phase");

    a_pending_only_released: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (phase_reg == bgc_pkg::PH_RELEASED))
        else $error("settle wait pending outside released phase");

    a_phase_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_now == phase_reg))
        else $error("reported phase differs from machine phase");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for the button gesture classifier: directed table, click bursts and random gestures.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bgc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int BURST_CLICKS = 257;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic              lvl;
        logic              tk;
        logic              fixed;
        bgc_pkg::gesture_t gest;
        bgc_pkg::phase_t   ph;
    } sample_t;

    typedef struct packed {
        bgc_pkg::gesture_t gest;
        bgc_pkg::phase_t   ph;
    } result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bgc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bgc_pkg::TIMER_W-1:0]   cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          button_level;
    logic                          tick;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    gesture_event;
    logic [1:0]                    phase_now;

    button_gesture_classifier_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .button_level  (button_level),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gesture_event (gesture_event),
        .phase_now     (phase_now)
    );

    // Timing registers as the block holds them
    logic [bgc_pkg::TIMER_W-1:0] debounce_len;
    logic [bgc_pkg::TIMER_W-1:0] settle_len;
    logic [bgc_pkg::TIMER_W-1:0] long_len;

    // Classifier state
    bgc_pkg::phase_t             cur_phase;
    logic [bgc_pkg::TIMER_W-1:0] ticks_left;
    logic [bgc_pkg::COUNT_W-1:0] n_short;
    logic [bgc_pkg::COUNT_W-1:0] n_long;
    logic                        prev_level;
    logic                        settling;

    sample_t    button_q[$];
    result_t    gesture_q[$];
    sample_t    drive_sample;
    idle_mode_t idle_mode;
    bit         sample_taken;
    bit         hold_request;
    int         n_pushed;
    int         n_accepted;
    int         fail_count;
    int         quiet_cycles;

    sample_t dir_rows [26] = '{
        '{1'b0, 1'b0, 1'b1, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b0, 1'b1, bgc_pkg::EV_NONE,   bgc_pkg::PH_DEBOUNCE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b1, bgc_pkg::EV_SINGLE, bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b1, bgc_pkg::EV_DOUBLE, bgc_pkg::PH_IDLE},
        '{1'b1, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b1, bgc_pkg::EV_LONG,   bgc_pkg::PH_IDLE},
        '{1'b1, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b0, 1'b0, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE},
        '{1'b0, 1'b1, 1'b1, bgc_pkg::EV_NONE,   bgc_pkg::PH_IDLE}
    };

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_pct(input bit receiver_side);
        case (idle_mode)
            IDLE_SENDER:   return receiver_side ? 0 : 73;
            IDLE_RECEIVER: return receiver_side ? 73 : 0;
            IDLE_BOTH:     return 22;
            default:       return 0;
        endcase
    endfunction

    task automatic predict_gesture(input logic lvl, input logic tk, output result_t res);
        logic done;
        res.gest = bgc_pkg::EV_NONE;
        if (tk && ticks_left != '0)
            ticks_left = ticks_left - 1'b1;
        done = (ticks_left == '0);
        case (cur_phase)
            bgc_pkg::PH_IDLE:
            begin
                if (!prev_level && lvl)
                begin
                    cur_phase = bgc_pkg::PH_DEBOUNCE;
                    ticks_left = debounce_len;
                end
            end
            bgc_pkg::PH_DEBOUNCE:
            begin
                if (done)
                begin
                    if (lvl)
                    begin
                        cur_phase = bgc_pkg::PH_PRESSED;
                        ticks_left = (long_len > debounce_len) ? long_len - debounce_len : '0;
                    end
                    else
                    begin
                        cur_phase = bgc_pkg::PH_RELEASED;
                    end
                end
            end
            bgc_pkg::PH_PRESSED:
            begin
                if (!lvl)
                begin
                    if (done)
                    begin
                        if (n_long != bgc_pkg::COUNT_MAX)
                            n_long = n_long + 1'b1;
                    end
                    else if (n_short != bgc_pkg::COUNT_MAX)
                    begin
                        n_short = n_short + 1'b1;
                    end
                    cur_phase = bgc_pkg::PH_RELEASED;
                    ticks_left = debounce_len;
                end
            end
            default:
            begin
                if (done)
                begin
                    if (!settling)
                    begin
                        ticks_left = settle_len;
                        settling = 1'b1;
                    end
                    else
                    begin
                        if (n_short == 1)
                            res.gest = bgc_pkg::EV_SINGLE;
                        else if (n_short == 2)
                            res.gest = bgc_pkg::EV_DOUBLE;
                        else if (n_long == 1)
                            res.gest = bgc_pkg::EV_LONG;
                        cur_phase = bgc_pkg::PH_IDLE;
                        n_short = '0;
                        n_long = '0;
                        settling = 1'b0;
                    end
                end
                else if (lvl && settling)
                begin
                    cur_phase = bgc_pkg::PH_DEBOUNCE;
                    ticks_left = debounce_len;
                    settling = 1'b0;
                end
            end
        endcase
        prev_level = lvl;
        res.ph = cur_phase;
    endtask

    // Check results, predict accepted samples, watch for a hang
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (gesture_q.size() == 0)
                begin
                    $error("unexpected transaction: gesture_event %0d phase_now %0d",
                           gesture_event, phase_now);
                    fail_count++;
                end
                else
                begin
                    want = gesture_q.pop_front();
                    if (gesture_event !== want.gest)
                    begin
                        $error("gesture_event: expected %0d, actual %0d", want.gest, gesture_event);
                        fail_count++;
                    end
                    if (phase_now !== want.ph)
                    begin
                        $error("phase_now: expected %0d, actual %0d", want.ph, phase_now);
                        fail_count++;
                    end
                end
            end
            sample_taken = in_valid && in_ready;
            if (sample_taken)
            begin
                predict_gesture(drive_sample.lvl, drive_sample.tk, got);
                if (drive_sample.fixed)
                begin
                    got.gest = drive_sample.gest;
                    got.ph = drive_sample.ph;
                end
                gesture_q.push_back(got);
                n_accepted++;
            end
            if (sample_taken || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : sender
        in_valid = 1'b0;
        button_level = 1'b0;
        tick = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && (!in_valid || sample_taken))
            begin
                if (button_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
                begin
                    drive_sample = button_q.pop_front();
                    in_valid <= 1'b1;
                    button_level <= drive_sample.lvl;
                    tick <= drive_sample.tk;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
            end
        end
    end

    task automatic write_reg(input logic [bgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgc_pkg::TIMER_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bgc_pkg::CFG_DEBOUNCE: debounce_len = val;
            bgc_pkg::CFG_SETTLE:   settle_len = val;
            bgc_pkg::CFG_LONG:     long_len = val;
            default:               ;
        endcase
    endtask

    task automatic set_timing(input logic [bgc_pkg::TIMER_W-1:0] deb,
                              input logic [bgc_pkg::TIMER_W-1:0] stl,
                              input logic [bgc_pkg::TIMER_W-1:0] lng);
        write_reg(bgc_pkg::CFG_DEBOUNCE, deb);
        write_reg(bgc_pkg::CFG_SETTLE, stl);
        write_reg(bgc_pkg::CFG_LONG, lng);
    endtask

    task automatic push_sample(input logic lvl, input logic tk);
        sample_t s;
        s.lvl = lvl;
        s.tk = tk;
        s.fixed = 1'b0;
        s.gest = bgc_pkg::EV_NONE;
        s.ph = bgc_pkg::PH_IDLE;
        button_q.push_back(s);
        n_pushed++;
    endtask

    task automatic wait_drained();
        while (!(n_accepted == n_pushed && gesture_q.size() == 0))
            @(negedge clk);
    endtask

    // One to three presses with occasional bounce, then a release long enough to report
    task automatic queue_gesture();
        int clicks;
        int span_hold;
        int span_gap;
        int n_hold;
        int n_gap;
        clicks = $urandom_range(1, 3);
        span_hold = debounce_len + long_len + 3;
        span_gap = debounce_len + settle_len + 3;
        repeat ($urandom_range(0, 2)) push_sample(1'b0, 1'($urandom_range(0, 1)));
        for (int c = 0; c < clicks; c++)
        begin
            n_hold = $urandom_range(1, span_hold);
            for (int i = 0; i < n_hold; i++)
                push_sample($urandom_range(0, 19) != 0, $urandom_range(0, 3) != 0);
            if (c == clicks - 1)
            begin
                for (int i = 0; i < span_gap + 1; i++)
                    push_sample($urandom_range(0, 29) == 0, 1'b1);
            end
            else
            begin
                n_gap = $urandom_range(1, span_gap);
                for (int i = 0; i < n_gap; i++)
                    push_sample($urandom_range(0, 19) == 0, $urandom_range(0, 3) != 0);
            end
        end
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 8))
            push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : stimulus
        int start;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bgc_pkg::CFG_DEBOUNCE;
        cfg_data = '0;
        idle_mode = IDLE_NONE;
        hold_request = 1'b0;
        sample_taken = 1'b0;
        n_pushed = 0;
        n_accepted = 0;
        fail_count = 0;
        quiet_cycles = 0;
        debounce_len = bgc_pkg::DEBOUNCE_RESET;
        settle_len = bgc_pkg::SETTLE_RESET;
        long_len = bgc_pkg::LONG_RESET;
        cur_phase = bgc_pkg::PH_IDLE;
        ticks_left = '0;
        n_short = '0;
        n_long = '0;
        prev_level = 1'b0;
        settling = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_timing(16'd1, 16'd1, 16'd3);
        write_reg(CFG_UNUSED, 16'($urandom));
        foreach (dir_rows[i])
        begin
            button_q.push_back(dir_rows[i]);
            n_pushed++;
        end
        wait_drained();

        // Saturate the short-press count with a long burst of clicks
        set_timing(16'd0, 16'd2, 16'hFFFF);
        idle_mode = IDLE_BOTH;
        push_sample(1'b1, 1'b0);
        repeat (BURST_CLICKS)
        begin
            push_sample(1'b1, 1'b0);
            push_sample(1'b0, 1'b0);
            push_sample(1'b0, 1'b0);
            push_sample(1'b1, 1'b0);
        end
        repeat (8) push_sample(1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                set_timing(16'd1, 16'd1, 16'd1);
            else
                set_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 12)));
            idle_mode = idle_mode_t'(p % 4);
            if (p == 2)
                hold_request = 1'b1;
            start = n_pushed;
            while (n_pushed - start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_gesture();
                else
                    queue_noise();
            end
            wait_drained();
        end

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_mode = IDLE_RECEIVER;
        repeat (30) push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_drained();

        repeat (4) @(posedge clk);
        if (fail_count == 0 && gesture_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
